// ----- hw/rtl/dirty_region_version_ring_core_defines.svh -----
// ----------------------------------------------------------------------------
// Dirty region version ring - assertion macros
// Shared concurrent assertion forms for the ring core.
// ----------------------------------------------------------------------------
`ifndef DIRTY_REGION_VERSION_RING_CORE_DEFINES_SVH
`define DIRTY_REGION_VERSION_RING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRVR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/drvr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drvr_pkg
// Fixed widths and op codes of the dirty region version ring.
// ----------------------------------------------------------------------------
package drvr_pkg;

    localparam int VER_W      = 32;   // world / client version
    localparam int IN_COORD_W = 32;   // coordinate field width on the ports
    localparam int MARGIN_W   = 16;   // expand margin register
    localparam int SUM_W      = 34;   // coord +/- margin without overflow

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd512;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

endpackage

// ----- hw/rtl/drvr_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drvr_item_if
// Input channel: record or check transaction with a box and client version.
// ----------------------------------------------------------------------------
interface drvr_item_if;
    import drvr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [IN_COORD_W-1:0] min_x;
    logic [IN_COORD_W-1:0] min_y;
    logic [IN_COORD_W-1:0] min_z;
    logic [IN_COORD_W-1:0] max_x;
    logic [IN_COORD_W-1:0] max_y;
    logic [IN_COORD_W-1:0] max_z;
    logic [VER_W-1:0]      client_version;

    modport source (
        output valid, op, min_x, min_y, min_z, max_x, max_y, max_z, client_version,
        input  ready
    );

    modport sink (
        input  valid, op, min_x, min_y, min_z, max_x, max_y, max_z, client_version,
        output ready
    );
endinterface

// ----- hw/rtl/drvr_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drvr_result_if
// Output channel: validity flag and version pair for each transaction.
// ----------------------------------------------------------------------------
interface drvr_result_if;
    import drvr_pkg::*;

    logic             valid;
    logic             ready;
    logic             still_valid;
    logic [VER_W-1:0] updated_version;
    logic [VER_W-1:0] current_version;

    modport source (
        output valid, still_valid, updated_version, current_version,
        input  ready
    );

    modport sink (
        input  valid, still_valid, updated_version, current_version,
        output ready
    );
endinterface

// ----- hw/rtl/dirty_region_version_ring_core.sv -----
`timescale 1ns / 1ps
// Steps: a record goes through S_REC and S_DONE; a check with equal or out-of-range
//   versions goes to S_DONE; a scanning check walks gap ring entries (gap <= RING_DEPTH).
// Throughput: one transaction at a time; the scan reads one ring entry per cycle from
//   the single-read-port box memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the box memory
//   with input ready low. Margin register writes are always taken.
// ----------------------------------------------------------------------------
// dirty_region_version_ring_core
// World version counter plus a ring memory of the last RING_DEPTH recorded
// boxes; answers whether a client's view is still valid for a query box.
// ----------------------------------------------------------------------------
`include "dirty_region_version_ring_core_defines.svh"

module dirty_region_version_ring_core #(
    parameter int RING_DEPTH = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [drvr_pkg::MARGIN_W-1:0] i_cfg_wr_data,
    drvr_item_if.sink                  i_in,
    drvr_result_if.source              o_out
);
    import drvr_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int GAP_W  = $clog2(RING_DEPTH + 1);
    localparam int BOX_W  = 6 * COORD_BITS;

    // Slot of version 2^32-1; used when a backward walk crosses version zero.
    localparam longint unsigned VER_MAX = 64'hFFFF_FFFF;
    localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(VER_MAX % RING_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

    // Saturation bounds of the signed COORD_BITS range, in the sum width.
    localparam logic signed [SUM_W-1:0] CMAX_S =
        $signed((SUM_W'(1) << (COORD_BITS - 1)) - SUM_W'(1));
    localparam logic signed [SUM_W-1:0] CMIN_S = -CMAX_S - SUM_W'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                r_state;
    logic [MARGIN_W-1:0]   r_margin;
    logic [VER_W-1:0]      r_ver;       // world version
    logic [SLOT_W-1:0]     r_head;      // r_ver mod RING_DEPTH
    logic [SLOT_W-1:0]     r_clr_addr;

    // query box of the transaction in flight: x, y, z
    t_coord                r_q_lo [3];
    t_coord                r_q_hi [3];

    // scan walk
    logic [GAP_W-1:0]      r_left;      // entries still to read
    logic [SLOT_W-1:0]     r_slot;      // next slot to read
    logic [VER_W-1:0]      r_walk;      // version held by r_slot
    logic                  r_rd_pend;   // r_rd_data holds an entry to test

    // result of the finished transaction, waiting for the output register
    logic                  r_res_valid;
    logic [VER_W-1:0]      r_res_upd;

    // output register
    logic                  r_o_valid;
    logic                  r_o_still_valid;
    logic [VER_W-1:0]      r_o_upd;
    logic [VER_W-1:0]      r_o_cur;

    // box memory: {min_x, min_y, min_z, max_x, max_y, max_z}
    logic [BOX_W-1:0]      r_mem [RING_DEPTH];
    logic [BOX_W-1:0]      r_rd_data;

    // ------------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------------
    logic                  in_fire;
    logic                  out_free;
    logic [VER_W-1:0]      gap;
    logic                  gap_stale;
    logic [VER_W-1:0]      n_ver;
    logic [SLOT_W-1:0]     n_head;
    logic [SLOT_W-1:0]     n_slot;
    logic [BOX_W-1:0]      rec_box;
    t_coord                ent_lo [3];
    t_coord                ent_hi [3];
    logic                  ent_hit;
    logic                  rd_en;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [BOX_W-1:0]      mem_wdata;

    function automatic t_coord sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        s = v;
        if (v > CMAX_S) begin
            s = CMAX_S;
        end else if (v < CMIN_S) begin
            s = CMIN_S;
        end
        return s[COORD_BITS-1:0];
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;

    // gap read as signed 32 bits: negative or beyond the ring depth is stale
    assign gap       = r_ver - i_in.client_version;
    assign gap_stale = gap[VER_W-1] || (gap > VER_W'(RING_DEPTH));

    // version increment; the head slot restarts at zero when the version wraps
    always_comb begin
        n_ver = r_ver + VER_W'(1);
        if (r_ver == '1) begin
            n_head = '0;
        end else if (r_head == LAST_SLOT) begin
            n_head = '0;
        end else begin
            n_head = r_head + SLOT_W'(1);
        end
    end

    // backward walk: slot of r_walk - 1
    always_comb begin
        if (r_walk == '0) begin
            n_slot = WRAP_SLOT;
        end else if (r_slot == '0) begin
            n_slot = LAST_SLOT;
        end else begin
            n_slot = r_slot - SLOT_W'(1);
        end
    end

    // widen the recorded box by the margin, saturating each corner
    always_comb begin
        logic signed [SUM_W-1:0] mg;
        t_coord                  lo [3];
        t_coord                  hi [3];
        mg = SUM_W'($signed({1'b0, r_margin}));
        for (int a = 0; a < 3; a++) begin
            lo[a] = sat_coord(SUM_W'(r_q_lo[a]) - mg);
            hi[a] = sat_coord(SUM_W'(r_q_hi[a]) + mg);
        end
        rec_box = {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    end

    // inclusive overlap of the query box with the entry just read
    always_comb begin
        ent_hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            ent_lo[a] = r_rd_data[BOX_W-1-a*COORD_BITS -: COORD_BITS];
            ent_hi[a] = r_rd_data[3*COORD_BITS-1-a*COORD_BITS -: COORD_BITS];
            if (!(r_q_lo[a] <= ent_hi[a] && ent_lo[a] <= r_q_hi[a])) begin
                ent_hit = 1'b0;
            end
        end
        ent_hit = ent_hit && r_rd_pend;
    end

    assign rd_en     = (r_state == S_SCAN) && !ent_hit && (r_left != '0);
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_REC);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : n_head;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : rec_box;

    // ------------------------------------------------------------------------
    // Box memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_slot];
        end
    end

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_margin <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Control FSM, version state and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ver      <= '0;
            r_head     <= '0;
            r_clr_addr <= '0;
            r_left     <= '0;
            r_rd_pend  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // output drains here; in S_DONE the refill below decides valid
            if (r_o_valid && o_out.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SLOT_W'(1);
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_fire) begin
                        r_q_lo[0] <= i_in.min_x[COORD_BITS-1:0];
                        r_q_lo[1] <= i_in.min_y[COORD_BITS-1:0];
                        r_q_lo[2] <= i_in.min_z[COORD_BITS-1:0];
                        r_q_hi[0] <= i_in.max_x[COORD_BITS-1:0];
                        r_q_hi[1] <= i_in.max_y[COORD_BITS-1:0];
                        r_q_hi[2] <= i_in.max_z[COORD_BITS-1:0];
                        r_res_upd <= i_in.client_version;
                        if (i_in.op == OP_RECORD) begin
                            r_state <= S_REC;
                        end else if (gap == '0) begin
                            r_res_valid <= 1'b1;
                            r_state     <= S_DONE;
                        end else if (gap_stale) begin
                            r_res_valid <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_left    <= gap[GAP_W-1:0];
                            r_slot    <= r_head;
                            r_walk    <= r_ver;
                            r_rd_pend <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end

                S_REC: begin
                    // box written to the new head slot by the memory port
                    r_ver       <= n_ver;
                    r_head      <= n_head;
                    r_res_valid <= 1'b1;
                    r_res_upd   <= n_ver;
                    r_state     <= S_DONE;
                end

                S_SCAN: begin
                    if (ent_hit) begin
                        r_res_valid <= 1'b0;
                        r_res_upd   <= r_ver - VER_W'(RING_DEPTH) - VER_W'(1);
                        r_rd_pend   <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (r_left != '0) begin
                        r_left    <= r_left - GAP_W'(1);
                        r_slot    <= n_slot;
                        r_walk    <= r_walk - VER_W'(1);
                        r_rd_pend <= 1'b1;
                    end else begin
                        // last entry tested without a hit
                        r_res_valid <= 1'b1;
                        r_res_upd   <= r_ver;
                        r_rd_pend   <= 1'b0;
                        r_state     <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_o_valid       <= 1'b1;
                        r_o_still_valid <= r_res_valid;
                        r_o_upd         <= r_res_upd;
                        r_o_cur         <= r_ver;
                        r_state         <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_o_valid;
    assign o_out.still_valid     = r_o_still_valid;
    assign o_out.updated_version = r_o_upd;
    assign o_out.current_version = r_o_cur;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DRVR_ASSERT_NEXT(a_rec_bumps_ver, i_clk, i_rst_n, r_state == S_REC,
        r_ver == $past(r_ver) + VER_W'(1), "record did not bump the version")
    `DRVR_ASSERT_NEXT(a_ver_only_on_rec, i_clk, i_rst_n, r_state != S_REC,
        $stable(r_ver), "version changed outside a record")
    `DRVR_ASSERT_NOW(a_scan_left_bound, i_clk, i_rst_n, r_state == S_SCAN,
        r_left <= GAP_W'(RING_DEPTH), "scan count beyond ring depth")

endmodule
